FILE: rtl/lcg48_pkg.sv
// Shared types, constants and helpers for the 48-bit LCG draw unit.
// No dependencies; used by lcg48_ctrl, lcg48_dp and lcg48_random_draw_unit.
package lcg48_pkg;

   // Field and state widths
   localparam int StateWidth = 48;
   localparam int RawWidth   = 31;
   localparam int RawLsb     = 17;
   localparam int WordWidth  = 32;
   localparam int CfgWidth   = 16;
   localparam int CsrIdWidth = 1;
   localparam int CmdWidth   = 3;
   localparam int StatWidth  = 2;
   localparam int MulWords   = 3;
   localparam int StepWidth  = $clog2(RawWidth);

   // Register reset values
   localparam logic [CfgWidth-1:0] AddendReset  = 16'd11;
   localparam logic [CfgWidth-1:0] SeedLowReset = 16'd13070;

   // Special operand values
   localparam logic [WordWidth-1:0] SeedAllOnes  = 32'hFFFF_FFFF;
   localparam logic [WordWidth-1:0] SpanMaxInt   = 32'h7FFF_FFFF;
   localparam logic [WordWidth-1:0] SpanMinusOne = 32'hFFFF_FFFF;

   typedef enum logic [CmdWidth-1:0] {
      CMD_RESEED  = 3'd0,
      CMD_LOAD    = 3'd1,
      CMD_RAW     = 3'd2,
      CMD_RANGE   = 3'd3,
      CMD_BOUNDED = 3'd4
   } cmd_type;

   typedef enum logic [StatWidth-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SPAN_MAX = 2'd1,
      STATUS_ZERO_MOD = 2'd2
   } status_type;

   typedef enum logic [CsrIdWidth-1:0] {
      CSR_ADDEND   = 1'b0,
      CSR_SEED_LOW = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_COMMIT,
      ST_RANGE,
      ST_DIV,
      ST_DONE
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic       capture;
      logic       seed_set;
      logic       load_set;
      logic       mul_start;
      logic       mul_step;
      logic [1:0] mul_sel;
      logic       commit;
      logic       range_mul;
      logic       div_step;
      logic       out_load;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    out_busy;
   } dp_status_type;

   // 16-bit words of the multiplier 0x5DEECE66D, low word first
   function automatic logic [CfgWidth-1:0] mult_word(input logic [1:0] sel);
      logic [CfgWidth-1:0] w;
      case (sel)
         2'd0: begin
            w = 16'hE66D;
         end
         2'd1: begin
            w = 16'hDEEC;
         end
         default: begin
            w = 16'h0005;
         end
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/lcg48_ctrl.sv
// Sequencer for the LCG draw unit: accept, reseed or load, multiply steps, range or divide steps, result.
// Depends on lcg48_pkg; drives lcg48_dp through dp_cmd_type.
module lcg48_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  lcg48_pkg::dp_status_type dp_status,
   output lcg48_pkg::dp_cmd_type    dp_cmd
);

   lcg48_pkg::ctrl_state_type state_ff, state_in;
   logic [lcg48_pkg::StepWidth-1:0] step_ff, step_in;
   logic mul_last, div_last;

   assign mul_last = (step_ff == lcg48_pkg::StepWidth'(lcg48_pkg::MulWords - 1));
   assign div_last = (step_ff == lcg48_pkg::StepWidth'(lcg48_pkg::RawWidth - 1));

   // State and step counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcg48_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Step counter restarts on every state change
   assign step_in = (state_in != state_ff) ? '0 : step_ff + 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcg48_pkg::ST_IDLE: begin
            if (req_valid) state_in = lcg48_pkg::ST_EXEC;
         end
         lcg48_pkg::ST_EXEC: begin
            case (dp_status.cmd)
               lcg48_pkg::CMD_RAW,
               lcg48_pkg::CMD_RANGE,
               lcg48_pkg::CMD_BOUNDED: begin
                  state_in = lcg48_pkg::ST_MUL;
               end
               default: begin
                  state_in = lcg48_pkg::ST_DONE;
               end
            endcase
         end
         lcg48_pkg::ST_MUL: begin
            if (mul_last) state_in = lcg48_pkg::ST_COMMIT;
         end
         lcg48_pkg::ST_COMMIT: begin
            case (dp_status.cmd)
               lcg48_pkg::CMD_RANGE: begin
                  state_in = lcg48_pkg::ST_RANGE;
               end
               lcg48_pkg::CMD_BOUNDED: begin
                  state_in = lcg48_pkg::ST_DIV;
               end
               default: begin
                  state_in = lcg48_pkg::ST_DONE;
               end
            endcase
         end
         lcg48_pkg::ST_RANGE: begin
            state_in = lcg48_pkg::ST_DONE;
         end
         lcg48_pkg::ST_DIV: begin
            if (div_last) state_in = lcg48_pkg::ST_DONE;
         end
         lcg48_pkg::ST_DONE: begin
            if (!dp_status.out_busy) state_in = lcg48_pkg::ST_IDLE;
         end
         default: begin
            state_in = lcg48_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready = 1'b0;
      dp_cmd    = '0;
      case (state_ff)
         lcg48_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            dp_cmd.capture = req_valid;
         end
         lcg48_pkg::ST_EXEC: begin
            case (dp_status.cmd)
               lcg48_pkg::CMD_RESEED: begin
                  dp_cmd.seed_set = 1'b1;
               end
               lcg48_pkg::CMD_LOAD: begin
                  dp_cmd.load_set = 1'b1;
               end
               lcg48_pkg::CMD_RAW,
               lcg48_pkg::CMD_RANGE,
               lcg48_pkg::CMD_BOUNDED: begin
                  dp_cmd.mul_start = 1'b1;
               end
               default: begin
                  dp_cmd.mul_start = 1'b0;
               end
            endcase
         end
         lcg48_pkg::ST_MUL: begin
            dp_cmd.mul_step = 1'b1;
            dp_cmd.mul_sel  = step_ff[1:0];
         end
         lcg48_pkg::ST_COMMIT: begin
            dp_cmd.commit = 1'b1;
         end
         lcg48_pkg::ST_RANGE: begin
            dp_cmd.range_mul = 1'b1;
         end
         lcg48_pkg::ST_DIV: begin
            dp_cmd.div_step = 1'b1;
         end
         lcg48_pkg::ST_DONE: begin
            dp_cmd.out_load = !dp_status.out_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

FILE: rtl/lcg48_dp.sv
// Datapath of the LCG draw unit: config registers, generator state, word-serial
// multiply, range product, bit-serial remainder and output register. Uses lcg48_pkg.
module lcg48_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [lcg48_pkg::CsrIdWidth-1:0]    csr_index,
   input  logic [lcg48_pkg::CfgWidth-1:0]      csr_write_data,
   input  logic [lcg48_pkg::CmdWidth-1:0]      req_command,
   input  logic [lcg48_pkg::WordWidth-1:0]     req_seed_value,
   input  logic [lcg48_pkg::StateWidth-1:0]    req_state_value,
   input  logic [lcg48_pkg::RawWidth-1:0]      req_range_size,
   input  logic signed [lcg48_pkg::WordWidth-1:0] req_low_bound,
   input  logic signed [lcg48_pkg::WordWidth-1:0] req_high_bound,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [lcg48_pkg::WordWidth-1:0] rsp_value,
   output logic [lcg48_pkg::StatWidth-1:0]     rsp_status,
   output logic [lcg48_pkg::StateWidth-1:0]    rsp_state_word,
   input  lcg48_pkg::dp_cmd_type               dp_cmd,
   output lcg48_pkg::dp_status_type            dp_status
);

   localparam int SW = lcg48_pkg::StateWidth;
   localparam int RW = lcg48_pkg::RawWidth;
   localparam int WW = lcg48_pkg::WordWidth;
   localparam int PW = 2 * RW;

   // Config registers
   logic [lcg48_pkg::CfgWidth-1:0] addend_ff, seed_low_ff;

   // Latched transaction
   lcg48_pkg::cmd_type cmd_ff;
   logic [WW-1:0]      seed_ff;
   logic [SW-1:0]      load_ff;
   logic [RW-1:0]      range_ff;
   logic [WW-1:0]      low_ff;
   logic [WW-1:0]      span_ff;

   // Working registers
   logic [SW-1:0] gen_state_ff;
   logic [SW-1:0] acc_ff, acc_in;
   logic [WW-1:0] mag_ff;
   logic [PW-1:0] prod_ff;
   logic [RW-1:0] quot_ff;
   logic [RW-1:0] rem_ff, rem_in;

   // Output register
   logic          rsp_valid_ff;
   logic [WW-1:0] rsp_value_ff, rsp_value_in;
   lcg48_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [SW-1:0] rsp_state_ff;

   logic [RW-1:0] raw;
   logic [WW-1:0] seed_eff;
   logic [WW-1:0] span_inc;
   logic [63:0]   part_prod;
   logic [SW-1:0] part_shift;
   logic [WW-1:0] rem_shift;

   assign raw = gen_state_ff[SW-1:lcg48_pkg::RawLsb];

   // Config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         addend_ff   <= lcg48_pkg::AddendReset;
         seed_low_ff <= lcg48_pkg::SeedLowReset;
      end else if (csr_write_enable) begin
         if (csr_index == lcg48_pkg::CSR_ADDEND) addend_ff <= csr_write_data;
         else seed_low_ff <= csr_write_data;
      end
   end

   // Transaction capture
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_ff   <= lcg48_pkg::cmd_type'(req_command);
         seed_ff  <= req_seed_value;
         load_ff  <= req_state_value;
         range_ff <= req_range_size;
         low_ff   <= req_low_bound;
         span_ff  <= req_high_bound - req_low_bound;
      end
   end

   // Reseed value, with an all-ones seed treated as zero
   assign seed_eff = (seed_ff == lcg48_pkg::SeedAllOnes) ? '0 : seed_ff;

   // Generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_state_ff <= '0;
      end else if (dp_cmd.seed_set) begin
         gen_state_ff <= {seed_eff, seed_low_ff};
      end else if (dp_cmd.load_set) begin
         gen_state_ff <= load_ff;
      end else if (dp_cmd.commit) begin
         gen_state_ff <= acc_ff;
      end
   end

   // One 48x16 partial product per cycle, placed at its word offset mod 2^48
   assign part_prod = 64'(gen_state_ff) * 64'(lcg48_pkg::mult_word(dp_cmd.mul_sel));
   always_comb begin
      case (dp_cmd.mul_sel)
         2'd0: begin
            part_shift = part_prod[SW-1:0];
         end
         2'd1: begin
            part_shift = {part_prod[SW-17:0], 16'h0000};
         end
         default: begin
            part_shift = {part_prod[SW-33:0], 32'h0000_0000};
         end
      endcase
   end
   assign acc_in = acc_ff + part_shift;

   // Divisor magnitude |span + 1|
   assign span_inc = span_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (dp_cmd.mul_start) begin
         acc_ff <= SW'(addend_ff);
         mag_ff <= span_inc[WW-1] ? (~span_inc + 1'b1) : span_inc;
      end else if (dp_cmd.mul_step) begin
         acc_ff <= acc_in;
      end
   end

   // Range product
   always_ff @(posedge clock) begin
      if (dp_cmd.range_mul) prod_ff <= PW'(raw) * PW'(range_ff);
   end

   // Restoring remainder, one dividend bit per cycle
   assign rem_shift = {rem_ff, quot_ff[RW-1]};
   assign rem_in = (rem_shift >= mag_ff) ? RW'(rem_shift - mag_ff) : RW'(rem_shift);

   always_ff @(posedge clock) begin
      if (dp_cmd.commit) begin
         quot_ff <= acc_ff[SW-1:lcg48_pkg::RawLsb];
         rem_ff  <= '0;
      end else if (dp_cmd.div_step) begin
         quot_ff <= {quot_ff[RW-2:0], 1'b0};
         rem_ff  <= rem_in;
      end
   end

   // Result selection
   always_comb begin
      rsp_value_in  = '0;
      rsp_status_in = lcg48_pkg::STATUS_OK;
      case (cmd_ff)
         lcg48_pkg::CMD_RAW: begin
            rsp_value_in = WW'(raw);
         end
         lcg48_pkg::CMD_RANGE: begin
            rsp_value_in = WW'(prod_ff[PW-1:RW]);
         end
         lcg48_pkg::CMD_BOUNDED: begin
            if (span_ff == lcg48_pkg::SpanMaxInt) begin
               rsp_value_in  = WW'(raw);
               rsp_status_in = lcg48_pkg::STATUS_SPAN_MAX;
            end else if (span_ff == lcg48_pkg::SpanMinusOne) begin
               rsp_value_in  = WW'(raw);
               rsp_status_in = lcg48_pkg::STATUS_ZERO_MOD;
            end else begin
               rsp_value_in = low_ff + WW'(rem_ff);
            end
         end
         default: begin
            rsp_value_in = '0;
         end
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.out_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_state_ff  <= gen_state_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_value          = rsp_value_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_state_word     = rsp_state_ff;
   assign dp_status.cmd      = cmd_ff;
   assign dp_status.out_busy = rsp_valid_ff && !rsp_ready;

endmodule

FILE: rtl/lcg48_random_draw_unit.sv
// Top level of the 48-bit LCG draw unit: controller plus datapath.
// Depends on lcg48_pkg, lcg48_ctrl and lcg48_dp.
//
//   Channel   Direction  Handshake                  Payload
//   req_*     in         req_valid / req_ready      command, seed, state, range, bounds
//   rsp_*     out        rsp_valid / rsp_ready      value, status, state_word
//   csr_*     in         csr_write_enable           csr_index, csr_write_data
//
// One transaction at a time. After the accept, reseed, load and unknown commands pass
// exec and done, which loads the result register; draws pass exec, the multiply steps,
// commit, range (range draw) or divide steps (bounded draw), then done; idle follows.
// The draw cost is set by the 3-step word-serial multiply and the 31-step
// restoring remainder. A finished result waits in the output register while
// the next transaction is taken; it stalls only if that register is still full.
// Synchronous reset clears the state to zero and the registers to their defaults.
module lcg48_random_draw_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [lcg48_pkg::CsrIdWidth-1:0]       csr_index,
   input  logic [lcg48_pkg::CfgWidth-1:0]         csr_write_data,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [lcg48_pkg::CmdWidth-1:0]         req_command,
   input  logic [lcg48_pkg::WordWidth-1:0]        req_seed_value,
   input  logic [lcg48_pkg::StateWidth-1:0]       req_state_value,
   input  logic [lcg48_pkg::RawWidth-1:0]         req_range_size,
   input  logic signed [lcg48_pkg::WordWidth-1:0] req_low_bound,
   input  logic signed [lcg48_pkg::WordWidth-1:0] req_high_bound,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [lcg48_pkg::WordWidth-1:0] rsp_value,
   output logic [lcg48_pkg::StatWidth-1:0]        rsp_status,
   output logic [lcg48_pkg::StateWidth-1:0]       rsp_state_word
);

   lcg48_pkg::dp_cmd_type    dp_cmd;
   lcg48_pkg::dp_status_type dp_status;

   // Sequencer
   lcg48_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // Datapath
   lcg48_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_command      (req_command),
      .req_seed_value   (req_seed_value),
      .req_state_value  (req_state_value),
      .req_range_size   (req_range_size),
      .req_low_bound    (req_low_bound),
      .req_high_bound   (req_high_bound),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value        (rsp_value),
      .rsp_status       (rsp_status),
      .rsp_state_word   (rsp_state_word),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status)
   );

endmodule

FILE: tb/tb_lcg48_random_draw_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for lcg48_random_draw_unit: directed corner draws, then random
// transactions under several register settings. Depends on lcg48_pkg and the RTL top level.
module tb_lcg48_random_draw_unit;

   localparam int CmdBits   = lcg48_pkg::CmdWidth;
   localparam int WordBits  = lcg48_pkg::WordWidth;
   localparam int StateBits = lcg48_pkg::StateWidth;
   localparam int RawBits   = lcg48_pkg::RawWidth;
   localparam int CfgBits   = lcg48_pkg::CfgWidth;
   localparam int StatBits  = lcg48_pkg::StatWidth;

   localparam int IdleLimit    = 4000;
   localparam int LongHoldOff  = 300;
   localparam int PhaseItems   = 250;
   localparam int PhaseCount   = 4;
   localparam int DrainCycles  = 40;
   localparam logic [CmdBits-1:0] CmdFirstUnused = 3'd5;
   localparam logic [CmdBits-1:0] CmdLastUnused  = 3'd7;
   localparam logic [StateBits-1:0] LcgMultiplier = 48'h5_DEEC_E66D;
   localparam logic signed [WordBits-1:0] IntMin = 32'sh8000_0000;
   localparam logic signed [WordBits-1:0] IntMax = 32'sh7FFF_FFFF;

   typedef struct {
      logic [CmdBits-1:0]          cmd;
      logic [WordBits-1:0]         seed;
      logic [StateBits-1:0]        load_value;
      logic [RawBits-1:0]          range_size;
      logic signed [WordBits-1:0]  lo;
      logic signed [WordBits-1:0]  hi;
   } draw_request_type;

   typedef struct {
      logic signed [WordBits-1:0]  value;
      logic [StatBits-1:0]         status;
      logic [StateBits-1:0]        state_word;
   } draw_result_type;

   // Scoreboard: tracks generator state and registers, queues predicted draws
   class draw_scoreboard;
      logic [StateBits-1:0] gen_state;
      logic [CfgBits-1:0]   addend;
      logic [CfgBits-1:0]   seed_low;
      draw_result_type      expected_draws[$];
      int                   error_count;

      function new();
         gen_state   = '0;
         addend      = lcg48_pkg::AddendReset;
         seed_low    = lcg48_pkg::SeedLowReset;
         error_count = 0;
      endfunction

      function void set_register(lcg48_pkg::csr_index_type idx, logic [CfgBits-1:0] data);
         if (idx == lcg48_pkg::CSR_ADDEND) begin
            addend = data;
         end else begin
            seed_low = data;
         end
      endfunction

      // one LCG step; returns bits 47..17 of the new state
      function logic [RawBits-1:0] advance_generator();
         gen_state = LcgMultiplier * gen_state + {32'd0, addend};
         return gen_state[StateBits-1:lcg48_pkg::RawLsb];
      endfunction

      function void note_request(draw_request_type rq);
         draw_result_type      res;
         logic [RawBits-1:0]   raw;
         logic [61:0]          scaled;
         logic [WordBits-1:0]  span;
         logic [WordBits-1:0]  divisor;
         logic [WordBits-1:0]  magnitude;
         logic [WordBits-1:0]  remainder;
         logic [WordBits-1:0]  sum;
         res.value  = '0;
         res.status = lcg48_pkg::STATUS_OK;
         case (rq.cmd)
            lcg48_pkg::CMD_RESEED: begin
               gen_state = {(rq.seed == lcg48_pkg::SeedAllOnes) ? 32'd0 : rq.seed, seed_low};
            end
            lcg48_pkg::CMD_LOAD: begin
               gen_state = rq.load_value;
            end
            lcg48_pkg::CMD_RAW: begin
               raw       = advance_generator();
               res.value = {1'b0, raw};
            end
            lcg48_pkg::CMD_RANGE: begin
               raw    = advance_generator();
               scaled = {31'd0, raw} * {31'd0, rq.range_size};
               res.value = (rq.range_size == '0) ? '0 : {1'b0, scaled[61:31]};
            end
            lcg48_pkg::CMD_BOUNDED: begin
               raw  = advance_generator();
               span = $unsigned(rq.hi) - $unsigned(rq.lo);
               if (span == lcg48_pkg::SpanMaxInt) begin
                  res.value  = {1'b0, raw};
                  res.status = lcg48_pkg::STATUS_SPAN_MAX;
               end else if (span == lcg48_pkg::SpanMinusOne) begin
                  res.value  = {1'b0, raw};
                  res.status = lcg48_pkg::STATUS_ZERO_MOD;
               end else begin
                  divisor   = span + 32'd1;
                  magnitude = divisor[WordBits-1] ? (32'd0 - divisor) : divisor;
                  remainder = {1'b0, raw} % magnitude;
                  sum       = $unsigned(rq.lo) + remainder;
                  res.value = $signed(sum);
               end
            end
            default: begin
               // unused command codes leave the state alone
            end
         endcase
         res.state_word = gen_state;
         expected_draws.push_back(res);
      endfunction

      function void check_response(draw_result_type got);
         draw_result_type exp_res;
         if (expected_draws.size() == 0) begin
            $error("unexpected response: value %0d status %0d state_word %h",
                   got.value, got.status, got.state_word);
            error_count++;
            return;
         end
         exp_res = expected_draws.pop_front();
         if (got.value !== exp_res.value) begin
            $error("value: expected %0d, got %0d", exp_res.value, got.value);
            error_count++;
         end
         if (got.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, got.status);
            error_count++;
         end
         if (got.state_word !== exp_res.state_word) begin
            $error("state_word: expected %h, got %h", exp_res.state_word, got.state_word);
            error_count++;
         end
      endfunction

      function int outstanding();
         return expected_draws.size();
      endfunction
   endclass

   logic                          clock;
   logic                          reset            = 1'b1;
   logic                          csr_write_enable = 1'b0;
   lcg48_pkg::csr_index_type      csr_index        = lcg48_pkg::CSR_ADDEND;
   logic [CfgBits-1:0]            csr_write_data   = '0;
   logic                          req_valid        = 1'b0;
   logic                          req_ready;
   logic [CmdBits-1:0]            req_command      = '0;
   logic [WordBits-1:0]           req_seed_value   = '0;
   logic [StateBits-1:0]          req_state_value  = '0;
   logic [RawBits-1:0]            req_range_size   = '0;
   logic signed [WordBits-1:0]    req_low_bound    = '0;
   logic signed [WordBits-1:0]    req_high_bound   = '0;
   logic                          rsp_valid;
   logic                          rsp_ready        = 1'b0;
   logic signed [WordBits-1:0]    rsp_value;
   logic [StatBits-1:0]           rsp_status;
   logic [StateBits-1:0]          rsp_state_word;

   draw_scoreboard draw_sb;
   int             hold_off_cycles = 0;
   bit             burst_mode      = 1'b0;
   int             idle_cycles     = 0;

   lcg48_random_draw_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_seed_value   (req_seed_value),
      .req_state_value  (req_state_value),
      .req_range_size   (req_range_size),
      .req_low_bound    (req_low_bound),
      .req_high_bound   (req_high_bound),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value        (rsp_value),
      .rsp_status       (rsp_status),
      .rsp_state_word   (rsp_state_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: ends the run when no transaction moves for too long
   initial begin
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IdleLimit) begin
            $display("lcg48_random_draw_unit verification failed");
            $finish;
         end
      end
   end

   // Response side: random stalls, one long hold-off on request, checks each transaction
   initial begin
      int              stall;
      draw_result_type got;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            stall           = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = burst_mode ? 0 : $urandom_range(0, 11);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.value      = rsp_value;
         got.status     = rsp_status;
         got.state_word = rsp_state_word;
         draw_sb.check_response(got);
      end
   end

   // Random fill for every field; callers override what matters
   function automatic draw_request_type base_request(logic [CmdBits-1:0] cmd);
      draw_request_type rq;
      rq.cmd        = cmd;
      rq.seed       = $urandom();
      rq.load_value = StateBits'({$urandom(), $urandom()});
      rq.range_size = RawBits'($urandom());
      rq.lo         = $signed($urandom());
      rq.hi         = $signed($urandom());
      return rq;
   endfunction

   function automatic draw_request_type random_request();
      draw_request_type rq;
      int               pick;
      int               shape;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         rq = base_request(lcg48_pkg::CMD_RESEED);
         if ($urandom_range(0, 9) == 0) rq.seed = lcg48_pkg::SeedAllOnes;
      end else if (pick < 15) begin
         rq = base_request(lcg48_pkg::CMD_LOAD);
      end else if (pick < 35) begin
         rq = base_request(lcg48_pkg::CMD_RAW);
      end else if (pick < 60) begin
         rq    = base_request(lcg48_pkg::CMD_RANGE);
         shape = $urandom_range(0, 9);
         case (shape)
            0: rq.range_size = '0;
            1: rq.range_size = '1;
            2: rq.range_size = 31'd1;
            3, 4, 5: rq.range_size = RawBits'($urandom_range(1, 1000));
            default: ;
         endcase
      end else if (pick < 95) begin
         rq    = base_request(lcg48_pkg::CMD_BOUNDED);
         shape = $urandom_range(0, 9);
         case (shape)
            0: rq.hi = rq.lo + IntMax;
            1: rq.hi = rq.lo - 32'sd1;
            2: rq.hi = rq.lo;
            3, 4, 5: rq.hi = rq.lo + $signed($urandom_range(0, 100));
            6: rq.hi = rq.lo - $signed($urandom_range(2, 100));
            default: ;
         endcase
      end else begin
         rq = base_request(CmdBits'($urandom_range(CmdFirstUnused, CmdLastUnused)));
      end
      return rq;
   endfunction

   // Offers one request after a random gap (none in burst mode) and waits for it to be taken
   task automatic offer_request(input draw_request_type rq);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= rq.cmd;
      req_seed_value  <= rq.seed;
      req_state_value <= rq.load_value;
      req_range_size  <= rq.range_size;
      req_low_bound   <= rq.lo;
      req_high_bound  <= rq.hi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      draw_sb.note_request(rq);
   endtask

   task automatic offer_seed(input logic [WordBits-1:0] seed);
      draw_request_type rq;
      rq      = base_request(lcg48_pkg::CMD_RESEED);
      rq.seed = seed;
      offer_request(rq);
   endtask

   task automatic offer_load(input logic [StateBits-1:0] load_value);
      draw_request_type rq;
      rq            = base_request(lcg48_pkg::CMD_LOAD);
      rq.load_value = load_value;
      offer_request(rq);
   endtask

   task automatic offer_range(input logic [RawBits-1:0] range_size);
      draw_request_type rq;
      rq            = base_request(lcg48_pkg::CMD_RANGE);
      rq.range_size = range_size;
      offer_request(rq);
   endtask

   task automatic offer_bounded(input logic signed [WordBits-1:0] lo,
                                input logic signed [WordBits-1:0] hi);
      draw_request_type rq;
      rq    = base_request(lcg48_pkg::CMD_BOUNDED);
      rq.lo = lo;
      rq.hi = hi;
      offer_request(rq);
   endtask

   // Stops offering and waits until every outstanding transaction has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (draw_sb.outstanding() > 0) @(posedge clock);
   endtask

   // Registers change only while the unit is idle
   task automatic program_registers(input logic [CfgBits-1:0] add_val,
                                    input logic [CfgBits-1:0] seed_val);
      drain_results();
      repeat (8) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= lcg48_pkg::CSR_ADDEND;
      csr_write_data   <= add_val;
      @(posedge clock);
      draw_sb.set_register(lcg48_pkg::CSR_ADDEND, add_val);
      csr_index      <= lcg48_pkg::CSR_SEED_LOW;
      csr_write_data <= seed_val;
      @(posedge clock);
      draw_sb.set_register(lcg48_pkg::CSR_SEED_LOW, seed_val);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Main sequence
   initial begin
      draw_request_type   rq;
      logic [CfgBits-1:0] add_val;
      logic [CfgBits-1:0] seed_val;
      draw_sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed corners under the reset register values
      offer_request(base_request(lcg48_pkg::CMD_RAW));
      offer_range('0);
      offer_seed(lcg48_pkg::SeedAllOnes);
      offer_request(base_request(lcg48_pkg::CMD_RAW));
      offer_seed(32'd0);
      offer_seed(32'hFFFF_FFFE);
      offer_load('1);
      offer_request(base_request(lcg48_pkg::CMD_RAW));
      offer_load('0);
      offer_range('1);
      offer_range(31'd1);
      offer_bounded(32'sd0, IntMax);
      offer_bounded(IntMin, -32'sd1);
      offer_bounded(32'sd1, 32'sd0);
      offer_bounded(IntMin, IntMax);
      offer_bounded(IntMax, IntMax);
      offer_bounded(IntMax, IntMin);
      offer_bounded(32'sd0, IntMin);
      offer_bounded(IntMin, IntMax - 32'sd1);
      offer_bounded(-32'sd5, 32'sd5);
      for (int c = CmdFirstUnused; c <= CmdLastUnused; c++) begin
         offer_request(base_request(CmdBits'(c)));
      end
      offer_load(StateBits'({$urandom(), $urandom()}));
      offer_request(random_request());

      // random phases, each with its own register setting
      for (int phase = 0; phase < PhaseCount; phase++) begin
         case (phase)
            0: begin
               add_val  = '0;
               seed_val = '0;
            end
            1: begin
               add_val  = '1;
               seed_val = '1;
            end
            default: begin
               add_val  = CfgBits'($urandom());
               seed_val = CfgBits'($urandom());
            end
         endcase
         program_registers(add_val, seed_val);
         for (int n = 0; n < PhaseItems; n++) begin
            if (phase == 1 && n == 20) hold_off_cycles = LongHoldOff;
            if (phase == 2) burst_mode = (n >= 50 && n < 150);
            if (phase == 3 && n == 120) drain_results();
            offer_request(random_request());
         end
         burst_mode = 1'b0;
      end

      // end of stimulus: wait for the last transactions, then settle
      drain_results();
      repeat (DrainCycles) @(posedge clock);
      if (draw_sb.outstanding() > 0) begin
         $error("%0d expected responses never arrived", draw_sb.outstanding());
         draw_sb.error_count++;
      end
      if (draw_sb.error_count == 0) begin
         $display("lcg48_random_draw_unit verification clean");
      end else begin
         $display("lcg48_random_draw_unit verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/lcg48_pkg.sv
rtl/lcg48_ctrl.sv
rtl/lcg48_dp.sv
rtl/lcg48_random_draw_unit.sv
tb/tb_lcg48_random_draw_unit.sv
